// File: rtl/bbc_pkg.sv
// shared types, codes and constants for the bracket balance checker
`timescale 1ns / 1ps

package bbc_pkg;

	// default nesting depth of the open-bracket stack
	localparam int DEFAULT_STACK_DEPTH = 64;

	// depth of the queue between front and back, and of the result queue
	localparam int OP_QUEUE_DEPTH  = 4;
	localparam int RES_QUEUE_DEPTH = 2;

	// bracket byte codes
	localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
	localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
	localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5b;
	localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5d;
	localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7b;
	localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7d;

	// bracket kind as kept on the stack
	typedef enum logic [1:0] {
		KIND_ROUND,
		KIND_SQUARE,
		KIND_CURLY
	} kind_t;

	// stack operation decided by the front
	typedef enum logic [1:0] {
		OP_NONE,
		OP_OPEN,
		OP_CLOSE
	} op_code_t;

	// classified byte handed from front to back
	typedef struct packed {
		op_code_t op;
		kind_t    kind;
		logic     last;
	} bbc_op_t;

	// one result transaction
	typedef struct packed {
		logic balanced;
		logic depth_overflow;
	} bbc_res_t;

endpackage

// File: rtl/bbc_fifo.sv
// small synchronous queue with registered fill count
`timescale 1ns / 1ps

module bbc_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);

endmodule

// File: rtl/bbc_front.sv
// front end: accepts bytes and classifies them into stack operations
`timescale 1ns / 1ps

module bbc_front (
	input  logic           push,
	input  logic           full,
	input  logic [7:0]     char_code,
	input  logic           end_of_string,
	output logic           op_wr,
	output bbc_pkg::bbc_op_t op_data
);
	import bbc_pkg::*;

	// byte decoder
	always_comb begin
		op_data.op   = OP_NONE;
		op_data.kind = KIND_ROUND;
		op_data.last = end_of_string;
		unique case (char_code)
			CHAR_ROUND_OPEN: begin
				op_data.op   = OP_OPEN;
				op_data.kind = KIND_ROUND;
			end
			CHAR_SQUARE_OPEN: begin
				op_data.op   = OP_OPEN;
				op_data.kind = KIND_SQUARE;
			end
			CHAR_CURLY_OPEN: begin
				op_data.op   = OP_OPEN;
				op_data.kind = KIND_CURLY;
			end
			CHAR_ROUND_CLOSE: begin
				op_data.op   = OP_CLOSE;
				op_data.kind = KIND_ROUND;
			end
			CHAR_SQUARE_CLOSE: begin
				op_data.op   = OP_CLOSE;
				op_data.kind = KIND_SQUARE;
			end
			CHAR_CURLY_CLOSE: begin
				op_data.op   = OP_CLOSE;
				op_data.kind = KIND_CURLY;
			end
			default: begin
				op_data.op = OP_NONE;
			end
		endcase
	end

	// accepted transaction goes into the operation queue
	assign op_wr = push && !full;

endmodule

// File: rtl/bbc_back.sv
// back end: open-bracket stack, sticky flags and result forming
`timescale 1ns / 1ps

module bbc_back #(
	parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  bbc_pkg::bbc_op_t  op_data,
	output logic              op_take,
	input  logic              res_full,
	output logic              res_wr,
	output bbc_pkg::bbc_res_t res_data
);
	import bbc_pkg::*;

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// stack body; top_q mirrors entry level-1, below_s1 holds entry level-2
	kind_t         stack_mem [STACK_DEPTH];
	kind_t         top_q;
	kind_t         below_s1;
	logic [LW-1:0] level_q;
	logic          mismatch_q;
	logic          overflow_q;

	logic          go;
	logic          push_en;
	kind_t         top_nx;
	logic [LW-1:0] level_nx;
	logic          mismatch_nx;
	logic          overflow_nx;
	logic [LW-1:0] level_fin;
	logic [LW-1:0] level_rd;
	logic [AW-1:0] rd_addr;

	// a last byte waits for room in the result queue
	assign go      = op_valid && (!op_data.last || !res_full);
	assign op_take = go;

	// one stack operation
	always_comb begin
		push_en     = 1'b0;
		top_nx      = top_q;
		level_nx    = level_q;
		mismatch_nx = mismatch_q;
		overflow_nx = overflow_q;
		case (op_data.op)
			OP_OPEN: begin
				if (level_q < LW'(STACK_DEPTH)) begin
					push_en  = 1'b1;
					level_nx = level_q + 1'b1;
					top_nx   = op_data.kind;
				end else begin
					overflow_nx = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (level_q == '0) begin
					mismatch_nx = 1'b1;
				end else begin
					level_nx = level_q - 1'b1;
					top_nx   = below_s1;
					if (top_q != op_data.kind) begin
						mismatch_nx = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// level after this cycle, cleared at end of string
	always_comb begin
		if (!go) begin
			level_fin = level_q;
		end else if (op_data.last) begin
			level_fin = '0;
		end else begin
			level_fin = level_nx;
		end
	end

	// prefetch the entry under the next top
	assign level_rd = level_fin - LW'(2);
	assign rd_addr  = (level_fin < LW'(2)) ? '0 : level_rd[AW-1:0];

	// stack memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (go && push_en) begin
			stack_mem[level_q[AW-1:0]] <= op_data.kind;
		end
		below_s1 <= stack_mem[rd_addr];
	end

	// top of stack cache
	always_ff @(posedge clk) begin
		if (go) begin
			top_q <= top_nx;
		end
	end

	// level and sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			mismatch_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (go) begin
			level_q    <= level_fin;
			mismatch_q <= op_data.last ? 1'b0 : mismatch_nx;
			overflow_q <= op_data.last ? 1'b0 : overflow_nx;
		end
	end

	// result on the last byte
	assign res_wr                  = go && op_data.last;
	assign res_data.balanced       = !mismatch_nx && !overflow_nx && (level_nx == '0);
	assign res_data.depth_overflow = overflow_nx;

endmodule

// File: rtl/bracket_balance_checker.sv
// top level of the bracket balance checker
`timescale 1ns / 1ps
//
// channel   direction  handshake            payload
// input     in         push / full          char_code, end_of_string
// result    out        empty / pop          balanced, depth_overflow
//
// one byte per cycle sustained while no last byte waits on a full result queue; a
// result passes the operation queue and the result queue registers before it leaves
// the throughput is set by the stack unit: one push or pop with its compare per cycle
// reset clears the queues, stack level and flags; stack contents need no clearing
// a full result queue stalls only a last byte; the operation queue absorbs the rest

module bracket_balance_checker #(
	parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_string,
	output logic       empty,
	input  logic       pop,
	output logic       balanced,
	output logic       depth_overflow
);
	import bbc_pkg::*;

	localparam int OPW  = $bits(bbc_op_t);
	localparam int RESW = $bits(bbc_res_t);

	logic     op_wr;
	bbc_op_t  op_in;
	bbc_op_t  op_head;
	logic     op_empty;
	logic     op_take;
	logic     res_wr;
	logic     res_full;
	bbc_res_t res_in;
	bbc_res_t res_head;
	logic [OPW-1:0]  op_head_bits;
	logic [RESW-1:0] res_head_bits;

	// classify incoming bytes
	bbc_front u_front (
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.op_wr         (op_wr),
		.op_data       (op_in)
	);

	// operation queue between front and back
	bbc_fifo #(
		.WIDTH (OPW),
		.DEPTH (OP_QUEUE_DEPTH)
	) u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_wr),
		.wr_data (op_in),
		.rd_en   (op_take),
		.rd_data (op_head_bits),
		.full    (full),
		.empty   (op_empty)
	);

	assign op_head = bbc_op_t'(op_head_bits);

	// stack execution
	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (!op_empty),
		.op_data  (op_head),
		.op_take  (op_take),
		.res_full (res_full),
		.res_wr   (res_wr),
		.res_data (res_in)
	);

	// result queue
	bbc_fifo #(
		.WIDTH (RESW),
		.DEPTH (RES_QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_in),
		.rd_en   (pop && !empty),
		.rd_data (res_head_bits),
		.full    (res_full),
		.empty   (empty)
	);

	assign res_head       = bbc_res_t'(res_head_bits);
	assign balanced       = res_head.balanced;
	assign depth_overflow = res_head.depth_overflow;

endmodule

// File: rtl/bbc_checker.sv
// port-level assertions for the bracket balance checker, with bind
`timescale 1ns / 1ps

module bbc_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic balanced,
	input logic depth_overflow
);

	// reset leaves both queues idle
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> (empty && !full))
		else $error("queues not idle under reset");

	// an overflowing string can never report balanced
	a_overflow_unbalanced: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && balanced) |-> !depth_overflow)
		else $error("balanced result with depth overflow");

	// input backs up only behind an undelivered result
	a_full_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input queue full with no result waiting");

	// a waiting result holds until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(balanced) && $stable(depth_overflow)))
		else $error("waiting result changed before pop");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.full           (full),
	.empty          (empty),
	.pop            (pop),
	.balanced       (balanced),
	.depth_overflow (depth_overflow)
);
